// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the decoder's checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/scd_pkg.sv -----
// ----------------------------------------------------------------------------
// Sprite command decoder package
// Types, codes and the command completion function shared by the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scd_pkg;

  localparam int BYTE_SLOTS = 8;
  localparam int EVQ_DEPTH  = 4;
  localparam int EVQ_AW     = $clog2(EVQ_DEPTH);

  localparam logic [7:0] LEAD_ONE   = 8'h20;
  localparam logic [7:0] LEAD_TWO   = 8'h40;
  localparam logic [7:0] LEAD_THREE = 8'h60;
  localparam logic [7:0] LEAD_FOUR  = 8'h80;
  localparam logic [7:0] LEAD_LEN   = 8'ha0;
  localparam logic [7:0] LEAD_STOP  = 8'hd0;
  localparam logic [7:0] LEAD_BYTE_LAST = 8'h26;
  localparam logic [7:0] LEAD_PAIR_LAST = 8'h42;
  localparam logic [7:0] LEAD_SLOT  = 8'h43;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic [1:0] STAT_TERM      = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_TRUNCATED = 2'd2;
  localparam logic [1:0] STAT_UNKNOWN   = 2'd3;

  localparam logic [3:0] TGT_DECAY = 4'd7;
  localparam logic [3:0] TGT_SLOT  = 4'd10;

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  typedef struct packed {
    logic       wr_valid;
    logic [3:0] target;
    logic [7:0] slot;
    logic [15:0] value;
    logic       done_valid;
    logic [1:0] status;
  } evt_t;

  // Builds the attribute write for a completed command; wr_valid is low
  // when the command has no defined meaning.
  function automatic evt_t finish_cmd(logic [7:0] lead, logic [7:0] p0, logic [7:0] p1);
    evt_t       ev;
    logic [7:0] offs;
    ev = '0;
    if (lead >= LEAD_ONE && lead <= LEAD_BYTE_LAST) begin
      offs = lead - LEAD_ONE;
      ev.wr_valid = 1'b1;
      ev.target   = offs[3:0];
      ev.value    = {8'h00, p0};
    end else if (lead >= LEAD_TWO && lead <= LEAD_PAIR_LAST) begin
      offs = lead - LEAD_TWO;
      ev.wr_valid = 1'b1;
      ev.target   = offs[3:0] + TGT_DECAY;
      ev.value    = {p0, p1};
    end else begin
      offs = '0;
      if (lead == LEAD_SLOT && {1'b0, p0} < 9'(BYTE_SLOTS)) begin
        ev.wr_valid = 1'b1;
        ev.target   = TGT_SLOT;
        ev.slot     = p0;
        ev.value    = {8'h00, p1};
      end
    end
    return ev;
  endfunction

endpackage

// ----- hdl/scd_front.sv -----
// ----------------------------------------------------------------------------
// Sprite command decoder front end
// Parses one word per cycle while accept is high and turns it into a write and/or done event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              end_flag,
  output logic              ev_push,
  output scd_pkg::evt_t     ev
);

  scd_pkg::phase_t phase_r, phase_nxt, phase_cmd;
  logic [7:0] lead_r, lead_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] p0_r, p0_nxt;
  logic [7:0] p1_r, p1_nxt;
  logic [1:0] stop_r, stop_nxt;
  logic [7:0] idx;
  logic [7:0] left_dec;
  logic       fin;

  assign left_dec = left_r - 8'd1;
  assign idx      = {5'd0, lead_r[7:5]} - left_r;

  always_comb begin
    phase_cmd = phase_r;
    unique case (phase_r)
      scd_pkg::PH_LEAD: begin
        if (data_byte == 8'h00 || data_byte >= scd_pkg::LEAD_STOP) begin
          phase_cmd = scd_pkg::PH_STOP;
        end else if (data_byte >= scd_pkg::LEAD_LEN) begin
          phase_cmd = scd_pkg::PH_LEN;
        end else if (data_byte >= scd_pkg::LEAD_ONE) begin
          phase_cmd = scd_pkg::PH_PAY;
        end
      end
      scd_pkg::PH_LEN: begin
        phase_cmd = (data_byte == 8'h00) ? scd_pkg::PH_LEAD : scd_pkg::PH_PAY;
      end
      scd_pkg::PH_PAY: begin
        if (left_dec == 8'h00) begin
          phase_cmd = scd_pkg::PH_LEAD;
        end
      end
      scd_pkg::PH_STOP: begin
        phase_cmd = scd_pkg::PH_STOP;
      end
      default: phase_cmd = phase_r;
    endcase
    phase_nxt = end_flag ? scd_pkg::PH_LEAD : phase_cmd;
  end

  always_comb begin
    lead_nxt = lead_r;
    left_nxt = left_r;
    p0_nxt   = p0_r;
    p1_nxt   = p1_r;
    stop_nxt = stop_r;
    fin      = 1'b0;
    unique case (phase_r)
      scd_pkg::PH_LEAD: begin
        lead_nxt = data_byte;
        p0_nxt   = 8'h00;
        p1_nxt   = 8'h00;
        if (data_byte == 8'h00) begin
          stop_nxt = scd_pkg::STAT_TERM;
        end else if (data_byte >= scd_pkg::LEAD_STOP) begin
          stop_nxt = scd_pkg::STAT_UNKNOWN;
        end else if (data_byte < scd_pkg::LEAD_LEN) begin
          left_nxt = {5'd0, data_byte[7:5]};
          fin      = (data_byte < scd_pkg::LEAD_ONE);
        end
      end
      scd_pkg::PH_LEN: begin
        left_nxt = data_byte;
        fin      = (data_byte == 8'h00);
      end
      scd_pkg::PH_PAY: begin
        if (lead_r < scd_pkg::LEAD_LEN) begin
          if (idx == 8'd0) begin
            p0_nxt = data_byte;
          end else if (idx == 8'd1) begin
            p1_nxt = data_byte;
          end
        end
        left_nxt = left_dec;
        fin      = (left_dec == 8'h00);
      end
      scd_pkg::PH_STOP: begin
        fin = 1'b0;
      end
      default: fin = 1'b0;
    endcase

    ev = '0;
    if (fin) begin
      ev = scd_pkg::finish_cmd(lead_nxt, p0_nxt, p1_nxt);
    end
    ev.done_valid = end_flag;
    if (phase_cmd == scd_pkg::PH_STOP) begin
      ev.status = stop_nxt;
    end else if (phase_cmd == scd_pkg::PH_LEAD) begin
      ev.status = scd_pkg::STAT_EXHAUSTED;
    end else begin
      ev.status = scd_pkg::STAT_TRUNCATED;
    end
    ev_push = accept & (ev.wr_valid | ev.done_valid);

    if (end_flag) begin
      lead_nxt = 8'h00;
      left_nxt = 8'h00;
      p0_nxt   = 8'h00;
      p1_nxt   = 8'h00;
      stop_nxt = scd_pkg::STAT_TERM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= scd_pkg::PH_LEAD;
      lead_r  <= 8'h00;
      left_r  <= 8'h00;
      p0_r    <= 8'h00;
      p1_r    <= 8'h00;
      stop_r  <= scd_pkg::STAT_TERM;
    end else if (accept) begin
      phase_r <= phase_nxt;
      lead_r  <= lead_nxt;
      left_r  <= left_nxt;
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

// ----- hdl/scd_evq.sv -----
// ----------------------------------------------------------------------------
// Sprite command decoder event queue
// Short queue of decoded events between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scd_evq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  scd_pkg::evt_t wr_ev,
  output logic          full,
  input  logic          pop,
  output scd_pkg::evt_t rd_ev,
  output logic          empty
);

  scd_pkg::evt_t mem [scd_pkg::EVQ_DEPTH];
  logic [scd_pkg::EVQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [scd_pkg::EVQ_AW:0]   count_r, count_nxt;
  logic                       do_push, do_pop;

  assign full    = (count_r == (scd_pkg::EVQ_AW+1)'(scd_pkg::EVQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_ev   = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push & ~do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop & ~do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ----- hdl/scd_back.sv -----
// ----------------------------------------------------------------------------
// Sprite command decoder back end
// Expands each event into one or two result words in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  scd_pkg::evt_t q_ev,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic          out_kind,
  output logic [3:0]    out_target,
  output logic [7:0]    out_slot_index,
  output logic [15:0]   out_value,
  output logic [1:0]    out_status,
  output logic          out_last
);

  scd_pkg::evt_t cur_r;
  logic          valid_r;
  logic          sel_done_r;
  logic          taken;
  logic          to_done;
  logic          load;

  assign taken   = out_pop & valid_r;
  assign to_done = taken & ~sel_done_r & cur_r.done_valid;
  assign load    = (~valid_r | (taken & ~to_done)) & ~q_empty;
  assign q_pop   = load;

  assign out_empty = ~valid_r;

  always_comb begin
    if (sel_done_r) begin
      out_kind       = scd_pkg::KIND_DONE;
      out_target     = 4'd0;
      out_slot_index = 8'h00;
      out_value      = 16'h0000;
      out_status     = cur_r.status;
      out_last       = 1'b1;
    end else begin
      out_kind       = scd_pkg::KIND_WRITE;
      out_target     = cur_r.target;
      out_slot_index = cur_r.slot;
      out_value      = cur_r.value;
      out_status     = scd_pkg::STAT_TERM;
      out_last       = ~cur_r.done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      sel_done_r <= 1'b0;
    end else if (to_done) begin
      sel_done_r <= 1'b1;
    end else if (load) begin
      valid_r    <= 1'b1;
      sel_done_r <= ~q_ev.wr_valid;
    end else if (taken) begin
      valid_r    <= 1'b0;
    end
  end

endmodule

// ----- hdl/sprite_command_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// Sprite command stream decoder
// Decodes command list words into sprite attribute writes and done words.
// ----------------------------------------------------------------------------
// Input channel: a word carries one command byte and an end mark; it is
// taken when in_push is high and in_full is low. Result channel: the oldest
// result sits on the out_ ports while out_empty is low and leaves when
// out_pop is high. A byte may cause no result, one attribute write, one
// done word, or a write followed by a done word; out_last marks the final
// result of each byte.
// Throughput is one input word per cycle while in_full is low. An event
// goes from the front end into the queue at the edge that accepts its
// input word, and from the queue into the output register once that
// register is free. A byte that yields both a write and a done word holds
// the output register for two pops.
// When the receiver stalls, the four-entry event queue fills and in_full
// rises; nothing is dropped. Reset returns the parser to expect a lead byte
// and empties the queue and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sprite_command_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_flag,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [3:0]  out_target,
  output logic [7:0]  out_slot_index,
  output logic [15:0] out_value,
  output logic [1:0]  out_status,
  output logic        out_last
);

  scd_pkg::evt_t front_ev;
  scd_pkg::evt_t q_ev;
  logic          ev_push;
  logic          q_empty;
  logic          q_pop;
  logic          accept;

  assign accept = in_push & ~in_full;

  scd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .end_flag  (in_end_flag),
    .ev_push   (ev_push),
    .ev        (front_ev)
  );

  scd_evq u_evq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ev_push),
    .wr_ev (front_ev),
    .full  (in_full),
    .pop   (q_pop),
    .rd_ev (q_ev),
    .empty (q_empty)
  );

  scd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_ev           (q_ev),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_kind       (out_kind),
    .out_target     (out_target),
    .out_slot_index (out_slot_index),
    .out_value      (out_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  `ASSERT_IMPLY(a_done_last, clk, rst_n, !out_empty && out_kind == scd_pkg::KIND_DONE,
    out_last, "Done word not marked last.")
  `ASSERT_IMPLY(a_done_clean, clk, rst_n, !out_empty && out_kind == scd_pkg::KIND_DONE,
    out_target == 4'd0 && out_value == 16'h0000 && out_slot_index == 8'h00,
    "Done word carries write fields.")
  `ASSERT_IMPLY(a_write_status, clk, rst_n, !out_empty && out_kind == scd_pkg::KIND_WRITE,
    out_status == scd_pkg::STAT_TERM && out_target <= scd_pkg::TGT_SLOT,
    "Write word has bad status or target.")
  `ASSERT_IMPLY(a_slot_range, clk, rst_n,
    !out_empty && out_kind == scd_pkg::KIND_WRITE && out_target == scd_pkg::TGT_SLOT,
    9'(out_slot_index) < 9'(scd_pkg::BYTE_SLOTS), "Byte slot index out of range.")

endmodule
